// ----- src/dtus_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes of the dirty-tile update scheduler.
// No dependencies; taken in by the top level, its checker and the testbench.
package dtus_pkg;

	typedef enum logic [2:0] {
		MODE_CONNECT = 3'd0,
		MODE_ACK     = 3'd1,
		MODE_CLIENT  = 3'd2,
		MODE_POLL    = 3'd3,
		MODE_RETX    = 3'd4,
		MODE_TICK    = 3'd5,
		MODE_CLOSE   = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		PH_VERSION = 3'd0,
		PH_AUTH    = 3'd1,
		PH_INIT    = 3'd2,
		PH_IDLE    = 3'd3,
		PH_UPDATE  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		MSG_VERSION     = 3'd0,
		MSG_AUTH_NONE   = 3'd1,
		MSG_SERVER_INIT = 3'd2,
		MSG_UPDATE_HDR  = 3'd3,
		MSG_UPDATE_TILE = 3'd4
	} msg_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_HS,
		SQ_SWEEP,
		SQ_ACK_RD,
		SQ_ACK_DR,
		SQ_ACK_WR,
		SQ_PT_CHK,
		SQ_PT_WR,
		SQ_SCAN_RD,
		SQ_SCAN,
		SQ_HDR,
		SQ_TILE
	} seq_t;

	localparam logic [7:0] MSGT_UPDATE_REQ = 8'd3;
	localparam logic [7:0] MSGT_POINTER    = 8'd5;

	// handshake message sent in a handshake phase
	function automatic msg_t hs_msg(input phase_t p);
		msg_t m;
		unique case (p)
			PH_VERSION: m = MSG_VERSION;
			PH_AUTH:    m = MSG_AUTH_NONE;
			PH_INIT:    m = MSG_SERVER_INIT;
			default:    m = MSG_VERSION;
		endcase
		return m;
	endfunction

	// where a send opportunity leads from a given phase
	function automatic seq_t send_next(input phase_t p);
		seq_t s;
		if (p == PH_UPDATE)
			s = SQ_SCAN_RD;
		else if (p == PH_VERSION || p == PH_AUTH || p == PH_INIT)
			s = SQ_HS;
		else
			s = SQ_IDLE;
		return s;
	endfunction

endpackage

// ----- src/dirty_tile_update_scheduler.sv -----
`timescale 1ns / 1ps
// Top level of the dirty-tile update scheduler: session phases, dirty-tile map
// and sent-tile list in two synchronous memories. Depends on dtus_pkg.
//
//  channel   | direction | handshake             | word
//  ----------+-----------+-----------------------+--------------------------------------
//  command   | in        | start & !busy         | mode, msg_type, pointer_x/y, incremental
//  config    | in        | cfg_valid & cfg_ready | cfg_data (batch_limit)
//  result    | out       | strobe, one cycle     | message, tile_count, tile_col/row, last
//
// Steps: a word that touches neither memory nor the result port ends in SQ_IDLE;
// a handshake result is sent from SQ_HS. A full refresh marks the dirty map row by
// row in SQ_SWEEP; a pointer mark reads its row in SQ_PT_CHK, writes it in SQ_PT_WR.
// An ack in update clears the sent tiles (SQ_ACK_RD/DR/WR). The scan reads the first row
// (SQ_SCAN_RD), picks tiles row by row (SQ_SCAN); SQ_HDR sends the header, SQ_TILE each tile.
// Reset clears phase, connection and the dirty map (per-row valid bits, no sweep);
// the sent list needs no clearing. Results cannot be stalled; busy holds off commands.
module dirty_tile_update_scheduler #(
	parameter int TILE_COLS   = 16,
	parameter int TILE_ROWS   = 16,
	parameter int TILE_WIDTH  = 8,
	parameter int TILE_HEIGHT = 8,
	parameter int MAX_BATCH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [7:0]  msg_type,
	input  logic [15:0] pointer_x,
	input  logic [15:0] pointer_y,
	input  logic        incremental,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	output logic        strobe,
	output logic [2:0]  message,
	output logic [4:0]  tile_count,
	output logic [3:0]  tile_col,
	output logic [3:0]  tile_row,
	output logic        last
);
	import dtus_pkg::*;

	localparam int CW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
	localparam int RW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
	localparam int BW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int NW = $clog2(MAX_BATCH + 1);
	localparam int EW = RW + CW;
	localparam logic [RW-1:0] LAST_ROW = RW'(TILE_ROWS - 1);

	// pixel to tile: multiply by a rounded-up reciprocal, exact for 16-bit input
	localparam int MULW = 34;
	localparam int SHX  = 16 + $clog2(TILE_WIDTH);
	localparam int SHY  = 16 + $clog2(TILE_HEIGHT);
	localparam logic [MULW-1:0] RECIP_X =
		MULW'(((64'd1 << SHX) + 64'(TILE_WIDTH) - 64'd1) / 64'(TILE_WIDTH));
	localparam logic [MULW-1:0] RECIP_Y =
		MULW'(((64'd1 << SHY) + 64'(TILE_HEIGHT) - 64'd1) / 64'(TILE_HEIGHT));

	// sequencer and session state
	seq_t            state_q, state_d;
	phase_t          phase_q, phase_d;
	logic            conn_q, conn_d;
	logic            sweep_scan_q, sweep_scan_d;
	logic [4:0]      batch_limit_q;
	logic [NW-1:0]   sent_count_q, sent_count_d;
	logic [NW-1:0]   idx_q, idx_d;
	logic [RW-1:0]   row_q, row_d;
	logic            fresh_q, fresh_d;
	logic [TILE_COLS-1:0] work_q, work_d;
	logic [CW-1:0]   ack_col_q, ack_col_d;
	logic [MULW-1:0] mulx_q, muly_q;

	// decode of the accepted word
	phase_t dec_phase;
	logic   dec_conn;
	logic   dec_sweep_scan;
	seq_t   dec_next;

	// dirty map: one row per entry, valid bits stand in for the reset clear
	logic [TILE_COLS-1:0] dirty_mem [TILE_ROWS];
	logic [TILE_ROWS-1:0] dirty_vld_q;
	logic [TILE_COLS-1:0] dirty_rdata_q;
	logic                 dirty_rvld_q;
	logic                 dirty_we;
	logic [RW-1:0]        dirty_waddr, dirty_raddr;
	logic [TILE_COLS-1:0] dirty_wdata;
	logic [TILE_COLS-1:0] dirty_row;

	// sent list: {row, col} of each tile in the last batch
	logic [EW-1:0] sent_mem [MAX_BATCH];
	logic [EW-1:0] sent_rdata_q;
	logic          sent_we;
	logic [BW-1:0] sent_waddr, sent_raddr;
	logic [EW-1:0] sent_wdata;
	logic [RW-1:0] ent_row;
	logic [CW-1:0] ent_col;
	logic          ent_in;

	logic                 accept;
	logic [NW-1:0]        limit;
	logic [NW-1:0]        idx_nx;
	logic [TILE_COLS-1:0] cur_row;
	logic [CW-1:0]        pick_col;
	logic                 pick_any;
	logic [MULW-1:0]      bx_full, by_full;
	logic                 pt_in;
	logic [CW-1:0]        pt_col;
	logic [RW-1:0]        pt_row;

	assign busy      = (state_q != SQ_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign idx_nx    = idx_q + 1'b1;

	// out-of-range limits: zero counts as one, large values saturate
	always_comb begin
		if (batch_limit_q == '0)
			limit = NW'(1);
		else if (int'(batch_limit_q) > MAX_BATCH)
			limit = NW'(MAX_BATCH);
		else
			limit = NW'(batch_limit_q);
	end

	assign dirty_row = dirty_rvld_q ? dirty_rdata_q : '0;
	assign cur_row   = fresh_q ? dirty_row : work_q;
	assign pick_any  = |cur_row;

	// lowest dirty column of the row under scan
	always_comb begin
		pick_col = '0;
		for (int i = TILE_COLS - 1; i >= 0; i--) begin
			if (cur_row[i])
				pick_col = CW'(i);
		end
	end

	assign bx_full = mulx_q >> SHX;
	assign by_full = muly_q >> SHY;
	assign pt_in   = (bx_full < MULW'(TILE_COLS)) && (by_full < MULW'(TILE_ROWS));
	assign pt_col  = bx_full[CW-1:0];
	assign pt_row  = by_full[RW-1:0];

	assign ent_row = sent_rdata_q[EW-1:CW];
	assign ent_col = sent_rdata_q[CW-1:0];
	assign ent_in  = (int'(ent_row) < TILE_ROWS) && (int'(ent_col) < TILE_COLS);

	// decode the command word against the current phase
	always_comb begin
		dec_phase      = phase_q;
		dec_conn       = conn_q;
		dec_sweep_scan = 1'b0;
		dec_next       = SQ_IDLE;
		unique case (mode)
			MODE_CONNECT: begin
				dec_conn  = 1'b1;
				dec_phase = PH_VERSION;
				dec_next  = SQ_HS;
			end
			MODE_ACK: begin
				if (conn_q) begin
					if (phase_q == PH_UPDATE) begin
						dec_next = SQ_ACK_RD;
					end else if (phase_q != PH_IDLE) begin
						dec_phase = phase_t'(phase_q + 3'd1);
						dec_next  = send_next(dec_phase);
					end
				end
			end
			MODE_CLIENT: begin
				if (conn_q) begin
					if (phase_q != PH_IDLE && phase_q != PH_UPDATE) begin
						dec_next = SQ_HS;
					end else if (msg_type == MSGT_POINTER) begin
						dec_next = SQ_PT_CHK;
					end else if (msg_type == MSGT_UPDATE_REQ && !incremental) begin
						dec_phase      = PH_UPDATE;
						dec_sweep_scan = 1'b1;
						dec_next       = SQ_SWEEP;
					end else begin
						dec_next = send_next(phase_q);
					end
				end
			end
			MODE_POLL: begin
				if (conn_q && (phase_q == PH_IDLE || phase_q == PH_UPDATE))
					dec_next = send_next(phase_q);
			end
			MODE_RETX: begin
				if (conn_q)
					dec_next = send_next(phase_q);
			end
			MODE_TICK: begin
				if (conn_q && phase_q == PH_IDLE) begin
					dec_phase = PH_UPDATE;
					dec_next  = SQ_SWEEP;
				end
			end
			MODE_CLOSE: begin
				dec_conn = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (accept)
					state_d = dec_next;
			end
			SQ_HS:
				state_d = SQ_IDLE;
			SQ_SWEEP: begin
				if (row_q == LAST_ROW)
					state_d = sweep_scan_q ? SQ_SCAN_RD : SQ_IDLE;
			end
			SQ_ACK_RD:
				state_d = (idx_q < sent_count_q) ? SQ_ACK_DR : SQ_SCAN_RD;
			SQ_ACK_DR:
				state_d = ent_in ? SQ_ACK_WR : SQ_ACK_RD;
			SQ_ACK_WR:
				state_d = (idx_nx < sent_count_q) ? SQ_ACK_DR : SQ_SCAN_RD;
			SQ_PT_CHK:
				state_d = pt_in ? SQ_PT_WR : send_next(phase_q);
			SQ_PT_WR:
				state_d = SQ_SCAN_RD;
			SQ_SCAN_RD:
				state_d = SQ_SCAN;
			SQ_SCAN: begin
				if (idx_q == limit || (!pick_any && row_q == LAST_ROW))
					state_d = SQ_HDR;
			end
			SQ_HDR:
				state_d = (sent_count_q == '0) ? SQ_IDLE : SQ_TILE;
			SQ_TILE:
				state_d = (idx_nx == sent_count_q) ? SQ_IDLE : SQ_TILE;
			default:
				state_d = SQ_IDLE;
		endcase
	end

	// memory control, datapath updates and result word
	always_comb begin
		phase_d      = phase_q;
		conn_d       = conn_q;
		sweep_scan_d = sweep_scan_q;
		sent_count_d = sent_count_q;
		idx_d        = idx_q;
		row_d        = row_q;
		fresh_d      = fresh_q;
		work_d       = work_q;
		ack_col_d    = ack_col_q;
		dirty_we     = 1'b0;
		dirty_waddr  = row_q;
		dirty_wdata  = '0;
		dirty_raddr  = row_q;
		sent_we      = 1'b0;
		sent_waddr   = idx_q[BW-1:0];
		sent_wdata   = {row_q, pick_col};
		sent_raddr   = idx_q[BW-1:0];
		strobe       = 1'b0;
		message      = MSG_VERSION;
		tile_count   = '0;
		tile_col     = '0;
		tile_row     = '0;
		last         = 1'b0;
		unique case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					phase_d      = dec_phase;
					conn_d       = dec_conn;
					sweep_scan_d = dec_sweep_scan;
					row_d        = '0;
					idx_d        = '0;
				end
			end
			SQ_HS: begin
				strobe  = 1'b1;
				message = hs_msg(phase_q);
				last    = 1'b1;
			end
			SQ_SWEEP: begin
				// mark the whole row dirty, advance
				dirty_we    = 1'b1;
				dirty_wdata = '1;
				row_d       = row_q + 1'b1;
			end
			SQ_ACK_RD: begin
				sent_raddr = idx_q[BW-1:0];
			end
			SQ_ACK_DR: begin
				if (ent_in) begin
					dirty_raddr = ent_row;
					row_d       = ent_row;
					ack_col_d   = ent_col;
				end else begin
					idx_d = idx_nx;
				end
			end
			SQ_ACK_WR: begin
				// drop the acknowledged tile, fetch the next list entry meanwhile
				dirty_we    = 1'b1;
				dirty_wdata = dirty_row & ~(TILE_COLS'(1) << ack_col_q);
				idx_d       = idx_nx;
				sent_raddr  = idx_nx[BW-1:0];
			end
			SQ_PT_CHK: begin
				dirty_raddr = pt_row;
			end
			SQ_PT_WR: begin
				dirty_we    = 1'b1;
				dirty_waddr = pt_row;
				dirty_wdata = dirty_row | (TILE_COLS'(1) << pt_col);
				phase_d     = PH_UPDATE;
			end
			SQ_SCAN_RD: begin
				dirty_raddr = '0;
				row_d       = '0;
				idx_d       = '0;
				fresh_d     = 1'b1;
			end
			SQ_SCAN: begin
				if (idx_q == limit) begin
					sent_count_d = idx_q;
					idx_d        = '0;
				end else if (pick_any) begin
					sent_we = 1'b1;
					idx_d   = idx_nx;
					work_d  = cur_row & (cur_row - 1'b1);
					fresh_d = 1'b0;
				end else if (row_q == LAST_ROW) begin
					// batch not full: phase back to idle
					sent_count_d = idx_q;
					idx_d        = '0;
					phase_d      = PH_IDLE;
				end else begin
					row_d       = row_q + 1'b1;
					dirty_raddr = row_q + 1'b1;
					fresh_d     = 1'b1;
				end
			end
			SQ_HDR: begin
				strobe     = 1'b1;
				message    = MSG_UPDATE_HDR;
				tile_count = 5'(sent_count_q);
				last       = (sent_count_q == '0);
				sent_raddr = '0;
			end
			SQ_TILE: begin
				strobe     = 1'b1;
				message    = MSG_UPDATE_TILE;
				tile_col   = 4'(ent_col);
				tile_row   = 4'(ent_row);
				last       = (idx_nx == sent_count_q);
				sent_raddr = idx_nx[BW-1:0];
				idx_d      = idx_nx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= SQ_IDLE;
			phase_q       <= PH_VERSION;
			conn_q        <= 1'b0;
			sweep_scan_q  <= 1'b0;
			batch_limit_q <= 5'd16;
			sent_count_q  <= '0;
			idx_q         <= '0;
			row_q         <= '0;
			fresh_q       <= 1'b0;
			dirty_vld_q   <= '0;
			dirty_rvld_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			conn_q       <= conn_d;
			sweep_scan_q <= sweep_scan_d;
			sent_count_q <= sent_count_d;
			idx_q        <= idx_d;
			row_q        <= row_d;
			fresh_q      <= fresh_d;
			if (cfg_valid && cfg_ready)
				batch_limit_q <= cfg_data;
			if (dirty_we)
				dirty_vld_q[dirty_waddr] <= 1'b1;
			dirty_rvld_q <= dirty_vld_q[dirty_raddr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		work_q    <= work_d;
		ack_col_q <= ack_col_d;
		if (accept) begin
			mulx_q <= MULW'(pointer_x) * RECIP_X;
			muly_q <= MULW'(pointer_y) * RECIP_Y;
		end
	end

	// dirty map memory
	always_ff @(posedge clk) begin
		if (dirty_we)
			dirty_mem[dirty_waddr] <= dirty_wdata;
		dirty_rdata_q <= dirty_mem[dirty_raddr];
	end

	// sent list memory
	always_ff @(posedge clk) begin
		if (sent_we)
			sent_mem[sent_waddr] <= sent_wdata;
		sent_rdata_q <= sent_mem[sent_raddr];
	end

endmodule

// ----- src/dtus_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the dirty-tile update scheduler, bound to the top level.
// Depends on dtus_pkg.
module dtus_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        strobe,
	input logic [2:0]  message,
	input logic [4:0]  tile_count,
	input logic        last
);
	import dtus_pkg::*;

	// a result word only while a command is in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result word outside a command");

	// the final word of a command ends the burst
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result word after last");

	// a header with tiles is followed at once by a tile word
	a_hdr_tile: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && message == MSG_UPDATE_HDR && !last |=>
			strobe && message == MSG_UPDATE_TILE)
		else $error("header not followed by tile");

	// handshake words stand alone and carry no count
	a_hs_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (message == MSG_VERSION || message == MSG_AUTH_NONE ||
			message == MSG_SERVER_INIT) |-> last && tile_count == 5'd0)
		else $error("handshake word malformed");

endmodule

bind dirty_tile_update_scheduler dtus_checker u_dtus_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of dirty_tile_update_scheduler: a directed table then random
// session traffic under several batch limits, every result word checked against the
// local session model or a typed table word. Depends on dtus_pkg and the top level only.
module testbench;
	import dtus_pkg::*;

	// grid geometry and batch cap as built into the block
	localparam int TILE_W     = 8;
	localparam int TILE_H     = 8;
	localparam int GRID_COLS  = 16;
	localparam int GRID_ROWS  = 16;
	localparam int BATCH_CAP  = 16;

	// the one mode code that the package leaves unnamed
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	// how a row of the directed table is checked
	localparam int unsigned CHK_MODEL = 0;	// words from the session model
	localparam int unsigned CHK_NONE  = 1;	// no word at all
	localparam int unsigned CHK_ONE   = 2;	// one handshake word, typed in the table

	localparam int SETTLE      = 64;		// cycles to let a wordless item finish
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_SETTING = 28;

	typedef struct {
		logic [2:0]  mode;
		logic [7:0]  kind;
		logic [15:0] px;
		logic [15:0] py;
		logic        inc;
	} cmd_word_t;

	typedef struct {
		logic [2:0] msg;
		logic [4:0] count;
		logic [3:0] col;
		logic [3:0] row;
		logic       last;
	} out_word_t;

	typedef struct {
		cmd_word_t   cmd;
		int unsigned check;
		logic [2:0]  msg;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [7:0]  msg_type;
	logic [15:0] pointer_x;
	logic [15:0] pointer_y;
	logic        incremental;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        strobe;
	logic [2:0]  message;
	logic [4:0]  tile_count;
	logic [3:0]  tile_col;
	logic [3:0]  tile_row;
	logic        last;

	dirty_tile_update_scheduler DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.msg_type   (msg_type),
		.pointer_x  (pointer_x),
		.pointer_y  (pointer_y),
		.incremental(incremental),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.message    (message),
		.tile_count (tile_count),
		.tile_col   (tile_col),
		.tile_row   (tile_row),
		.last       (last)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------------------------
	// Session model: own copy of phase, connection, dirty map, sent list and limit.
	// ---------------------------------------------------------------------------------
	phase_t      ph        = PH_VERSION;
	bit          linked    = 1'b0;
	logic [15:0] dirty_map [GRID_ROWS];
	logic [3:0]  sent_col  [BATCH_CAP];
	logic [3:0]  sent_row  [BATCH_CAP];
	int          sent_n    = 0;
	logic [4:0]  batch_reg = 5'd16;

	out_word_t   fresh_words[$];		// words that the latest command causes
	out_word_t   pending_words[$];		// words still owed by the block
	out_word_t   owed;
	int          faults = 0;
	int          cycles = 0;
	int          calm   = 0;			// items left in a run with no gaps

	initial begin
		foreach (dirty_map[r])
			dirty_map[r] = '0;
	end

	// One send turn: a handshake word, or a header and a batch of dirty tiles.
	task automatic take_send_turn();
		int lim;
		int n;
		out_word_t w;
		if (ph == PH_VERSION || ph == PH_AUTH || ph == PH_INIT) begin
			w = '{msg: 3'(ph), count: '0, col: '0, row: '0, last: 1'b1};
			fresh_words.push_back(w);
			return;
		end
		if (ph != PH_UPDATE)
			return;
		// a limit of zero behaves as one, anything past the cap as the cap
		lim = (batch_reg == 0) ? 1 : (batch_reg > BATCH_CAP) ? BATCH_CAP : int'(batch_reg);
		n = 0;
		for (int r = 0; r < GRID_ROWS; r++)
			for (int c = 0; c < GRID_COLS; c++)
				if (n < lim && dirty_map[r][c]) begin
					sent_col[n] = 4'(c);
					sent_row[n] = 4'(r);
					n++;
				end
		sent_n = n;
		// a batch that is not full means the map is drained
		if (n != lim)
			ph = PH_IDLE;
		w = '{msg: MSG_UPDATE_HDR, count: 5'(n), col: '0, row: '0, last: (n == 0)};
		fresh_words.push_back(w);
		for (int k = 0; k < n; k++) begin
			w = '{msg: MSG_UPDATE_TILE, count: '0, col: sent_col[k], row: sent_row[k],
				last: (k == n - 1)};
			fresh_words.push_back(w);
		end
	endtask

	// Advance the session by one accepted command, leaving its words in fresh_words.
	task automatic predict_session(input cmd_word_t c);
		fresh_words.delete();
		case (c.mode)
			MODE_CONNECT: begin
				// a reconnect restarts the handshake but keeps the map
				linked = 1'b1;
				ph = PH_VERSION;
				take_send_turn();
			end
			MODE_ACK: begin
				if (linked) begin
					if (ph < PH_IDLE)
						ph = phase_t'(ph + 1);
					else if (ph == PH_UPDATE)
						for (int i = 0; i < sent_n; i++)
							dirty_map[sent_row[i]][sent_col[i]] = 1'b0;
					take_send_turn();
				end
			end
			MODE_CLIENT: begin
				if (linked) begin
					// in the handshake the message is dropped, the send turn stays
					if (ph >= PH_IDLE) begin
						if (c.kind == MSGT_POINTER) begin
							if (int'(c.px) / TILE_W < GRID_COLS &&
									int'(c.py) / TILE_H < GRID_ROWS) begin
								dirty_map[int'(c.py) / TILE_H][int'(c.px) / TILE_W] = 1'b1;
								ph = PH_UPDATE;
							end
						end else if (c.kind == MSGT_UPDATE_REQ && !c.inc) begin
							foreach (dirty_map[r])
								dirty_map[r] = '1;
							ph = PH_UPDATE;
						end
					end
					take_send_turn();
				end
			end
			MODE_POLL: begin
				if (linked && ph >= PH_IDLE)
					take_send_turn();
			end
			MODE_RETX: begin
				if (linked)
					take_send_turn();
			end
			MODE_TICK: begin
				if (linked && ph == PH_IDLE) begin
					foreach (dirty_map[r])
						dirty_map[r] = '1;
					ph = PH_UPDATE;
				end
			end
			MODE_CLOSE: linked = 1'b0;
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------------
	function automatic plan_row_t plan_row(input logic [2:0] m, input logic [7:0] k,
			input logic [15:0] x, input logic [15:0] y, input logic i,
			input int unsigned chk, input logic [2:0] em);
		plan_row_t p;
		p.cmd = '{mode: m, kind: k, px: x, py: y, inc: i};
		p.check = chk;
		p.msg = em;
		return p;
	endfunction

	// Gap before the next command: mostly none or short, now and then long,
	// with occasional back-to-back runs.
	function automatic int pick_gap();
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm = $urandom_range(6, 14);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Draw a command shaped by where the session stands: mostly well-formed steps
	// with random content, the rest noise with every field random.
	task automatic roll_command(output cmd_word_t c);
		int r;
		c.mode = 3'($urandom_range(0, 7));
		c.kind = 8'($urandom_range(0, 255));
		c.px   = 16'($urandom_range(0, 65535));
		c.py   = 16'($urandom_range(0, 65535));
		c.inc  = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (!linked) begin
			if (r < 80)
				c.mode = MODE_CONNECT;
		end else if (ph < PH_IDLE) begin
			if (r < 75)
				c.mode = MODE_ACK;
			else if (r < 82)
				c.mode = MODE_RETX;
			else if (r < 88)
				c.mode = MODE_CLIENT;
			else if (r < 93)
				c.mode = MODE_POLL;
		end else if (ph == PH_IDLE) begin
			if (r < 40) begin
				c.mode = MODE_CLIENT;
				c.kind = MSGT_POINTER;
				c.px   = 16'($urandom_range(0, GRID_COLS * TILE_W - 1));
				c.py   = 16'($urandom_range(0, GRID_ROWS * TILE_H - 1));
			end else if (r < 48) begin
				c.mode = MODE_CLIENT;
				c.kind = MSGT_POINTER;
			end else if (r < 56) begin
				c.mode = MODE_CLIENT;
				c.kind = MSGT_UPDATE_REQ;
			end else if (r < 64)
				c.mode = MODE_TICK;
			else if (r < 76)
				c.mode = MODE_POLL;
			else if (r < 83)
				c.mode = MODE_ACK;
			else if (r < 90)
				c.mode = MODE_CLIENT;
		end else begin
			if (r < 55)
				c.mode = MODE_ACK;
			else if (r < 65)
				c.mode = MODE_POLL;
			else if (r < 72)
				c.mode = MODE_RETX;
			else if (r < 82) begin
				c.mode = MODE_CLIENT;
				c.kind = MSGT_POINTER;
				c.px   = 16'($urandom_range(0, GRID_COLS * TILE_W - 1));
				c.py   = 16'($urandom_range(0, GRID_ROWS * TILE_H - 1));
			end else if (r < 86)
				c.mode = MODE_TICK;
			else if (r < 89) begin
				c.mode = MODE_CLIENT;
				c.kind = MSGT_UPDATE_REQ;
			end
		end
	endtask

	// Present one command after the given gap and hold it until the block takes it,
	// then book the words it owes. Start stays high across back-to-back commands.
	task automatic issue(input cmd_word_t c, input int gap, input int unsigned check,
			input logic [2:0] typed_msg);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode        <= c.mode;
		msg_type    <= c.kind;
		pointer_x   <= c.px;
		pointer_y   <= c.py;
		incremental <= c.inc;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
		predict_session(c);
		if (check == CHK_MODEL)
			foreach (fresh_words[i])
				pending_words.push_back(fresh_words[i]);
		else if (check == CHK_ONE)
			pending_words.push_back('{msg: typed_msg, count: '0, col: '0, row: '0,
				last: 1'b1});
	endtask

	// Drop start and let the block drain, wordless work included.
	task automatic quiesce();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------------------
	// Result monitor: every strobed word must match the oldest one owed.
	// Fields are listed as msg/count/col/row/last.
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_words.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected word: msg %0d count %0d col %0d row %0d last %0d",
						message, tile_count, tile_col, tile_row, last);
			end else begin
				owed = pending_words.pop_front();
				if (message !== owed.msg || tile_count !== owed.count ||
						tile_col !== owed.col || tile_row !== owed.row ||
						last !== owed.last) begin
					faults++;
					if (faults <= 10)
						$display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
							owed.msg, owed.count, owed.col, owed.row, owed.last,
							message, tile_count, tile_col, tile_row, last);
				end
			end
		end
	end

	// Hard stop should the block hang.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------------
	plan_row_t plan[$];
	cmd_word_t cmd;
	logic [4:0] limit_word;

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		mode        <= MODE_CONNECT;
		msg_type    <= '0;
		pointer_x   <= '0;
		pointer_y   <= '0;
		incremental <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table, at the reset batch limit. Handshake words and silent rows
		// are typed in; the rest comes from the session model.
		// nothing happens before a connect
		plan.push_back(plan_row(MODE_ACK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_POLL, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_RETX, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_TICK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_CLIENT, MSGT_POINTER, 16'd0, 16'd0, 1'b0, CHK_NONE,
			MSG_VERSION));
		plan.push_back(plan_row(MODE_UNUSED, 8'hff, 16'hffff, 16'hffff, 1'b1, CHK_NONE,
			MSG_VERSION));
		// handshake: a client message there is dropped but still sends
		plan.push_back(plan_row(MODE_CONNECT, 8'd0, 16'd0, 16'd0, 1'b0, CHK_ONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_CLIENT, MSGT_POINTER, 16'd10, 16'd10, 1'b0, CHK_ONE,
			MSG_VERSION));
		plan.push_back(plan_row(MODE_POLL, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_RETX, 8'd0, 16'd0, 16'd0, 1'b0, CHK_ONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_ACK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_ONE, MSG_AUTH_NONE));
		plan.push_back(plan_row(MODE_ACK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_ONE,
			MSG_SERVER_INIT));
		// idle sends nothing
		plan.push_back(plan_row(MODE_ACK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_POLL, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		// pointer at both grid corners; the first tile stays remembered, not cleared
		plan.push_back(plan_row(MODE_CLIENT, MSGT_POINTER, 16'd0, 16'd0, 1'b0, CHK_MODEL,
			MSG_VERSION));
		plan.push_back(plan_row(MODE_ACK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_CLIENT, MSGT_POINTER, 16'd127, 16'd127, 1'b0, CHK_MODEL,
			MSG_VERSION));
		// pointers off the grid, other message types, incremental request: silent
		plan.push_back(plan_row(MODE_CLIENT, MSGT_POINTER, 16'd128, 16'd0, 1'b0, CHK_NONE,
			MSG_VERSION));
		plan.push_back(plan_row(MODE_CLIENT, MSGT_POINTER, 16'hffff, 16'hffff, 1'b0, CHK_NONE,
			MSG_VERSION));
		plan.push_back(plan_row(MODE_CLIENT, 8'hff, 16'd5, 16'd5, 1'b0, CHK_NONE,
			MSG_VERSION));
		plan.push_back(plan_row(MODE_CLIENT, MSGT_UPDATE_REQ, 16'd0, 16'd0, 1'b1, CHK_NONE,
			MSG_VERSION));
		// full refresh, then batches on ack, retransmit and poll; a tick mid-update is silent
		plan.push_back(plan_row(MODE_CLIENT, MSGT_UPDATE_REQ, 16'd0, 16'd0, 1'b0, CHK_MODEL,
			MSG_VERSION));
		plan.push_back(plan_row(MODE_ACK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_MODEL, MSG_VERSION));
		plan.push_back(plan_row(MODE_RETX, 8'd0, 16'd0, 16'd0, 1'b0, CHK_MODEL, MSG_VERSION));
		plan.push_back(plan_row(MODE_TICK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_POLL, 8'd0, 16'd0, 16'd0, 1'b0, CHK_MODEL, MSG_VERSION));
		// close silences the session; reconnect twice, the second while connected
		plan.push_back(plan_row(MODE_CLOSE, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_ACK, 8'd0, 16'd0, 16'd0, 1'b0, CHK_NONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_CONNECT, 8'd0, 16'd0, 16'd0, 1'b0, CHK_ONE, MSG_VERSION));
		plan.push_back(plan_row(MODE_CONNECT, 8'd0, 16'd0, 16'd0, 1'b0, CHK_ONE, MSG_VERSION));

		foreach (plan[i])
			issue(plan[i].cmd, pick_gap(), plan[i].check, plan[i].msg);

		// Random traffic under several limits: zero, one, past the cap, the cap,
		// and one drawn at random. The session carries over between settings.
		for (int s = 0; s < 5; s++) begin
			case (s)
				0: limit_word = 5'd0;
				1: limit_word = 5'd1;
				2: limit_word = 5'd31;
				3: limit_word = 5'd16;
				default: limit_word = 5'($urandom_range(2, 15));
			endcase
			quiesce();
			cfg_data  <= limit_word;
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			batch_reg = limit_word;
			for (int n = 0; n < RAND_PER_SETTING; n++) begin
				roll_command(cmd);
				issue(cmd, pick_gap(), CHK_MODEL, MSG_VERSION);
			end
		end

		// drain, then allow for trailing work
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (faults == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
